@@ rtl/lctcm_pkg.sv @@
// Shared types and constants for the LRU cache tree cost unit.
package lctcm_pkg;

  localparam int NODES_DEF    = 16;
  localparam int WAYS_DEF     = 8;
  localparam int KEY_BITS_DEF = 32;
  localparam int IN_KEY_W     = 32;
  localparam int NODE_W       = 4;
  localparam int CAP_W        = 4;
  localparam int COST_W       = 3;
  localparam int RCOST_W      = 7;
  localparam int QCOST_W      = 8;
  localparam int TOTAL_W      = 48;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_LOOK,
    ST_DONE
  } lctcm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic do_load;
    logic do_read;
    logic do_look;
    logic do_done;
  } lctcm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_load;
    logic walk_end;
  } lctcm_sts_t;

  function automatic logic [COST_W-1:0] cost_of(input logic [CAP_W-1:0] cap);
    logic [COST_W-1:0] c;
    c = 3'd1;
    for (int i = 1; i < CAP_W; i++) begin
      if (cap[i]) c = COST_W'(i + 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/lctcm_ctrl.sv @@
// Controller state machine for the LRU cache tree cost unit.
module lctcm_ctrl import lctcm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  lctcm_sts_t sts,
  output lctcm_cmd_t cmd,
  output logic       busy
);

  lctcm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts.is_load) begin
          cmd.do_load = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.do_read = 1'b1;
        state_nxt   = sts.walk_end ? ST_DONE : ST_LOOK;
      end
      ST_LOOK: begin
        cmd.do_look = 1'b1;
        state_nxt   = sts.walk_end ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        cmd.do_done = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/lctcm_dp.sv @@
// Datapath for the LRU cache tree cost unit: node tables, tag memory, cost sums.
module lctcm_dp import lctcm_pkg::*; #(
  parameter int NODES    = NODES_DEF,
  parameter int WAYS     = WAYS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lctcm_cmd_t          cmd,
  output lctcm_sts_t          sts,
  input  logic                in_op,
  input  logic [NODE_W-1:0]   in_node,
  input  logic [IN_KEY_W-1:0] in_key,
  input  logic [NODE_W-1:0]   in_parent_node,
  input  logic [CAP_W-1:0]    in_capacity,
  input  logic                cfg_we,
  input  logic [RCOST_W-1:0]  cfg_wdata,
  output logic                out_valid,
  output logic [QCOST_W-1:0]  out_query_cost,
  output logic [TOTAL_W-1:0]  out_total_cost
);

  localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FW  = $clog2(WAYS + 1);
  localparam int LW  = $clog2(NODES + 1);
  localparam int KW  = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Per-node tables, flip-flops with reset values.
  logic [NW-1:0]     parent_r [NODES];
  logic [FW-1:0]     cap_r    [NODES];
  logic [COST_W-1:0] cost_r   [NODES];
  logic [FW-1:0]     fill_r   [NODES];
  // Tag and rank store: one row per node, read and written a row at a time.
  logic [WAYS-1:0][KW-1:0] tag_mem  [NODES];
  logic [WAYS-1:0][WW-1:0] rank_mem [NODES];

  logic [RCOST_W-1:0] root_cost_r;
  logic               op_r;
  logic [NW-1:0]      node_r;
  logic [KW-1:0]      key_r;
  logic [NW-1:0]      par_r;
  logic [FW-1:0]      cap_in_r;
  logic [NW-1:0]      cur_r;
  logic [LW-1:0]      level_r;
  logic [QCOST_W:0]   qcost_r;
  logic [TOTAL_W-1:0] total_r;
  logic [WAYS-1:0][KW-1:0] tags_r;
  logic [WAYS-1:0][WW-1:0] ranks_r;
  logic [FW-1:0]      fill_q_r;
  logic [FW-1:0]      cap_q_r;
  logic [COST_W-1:0]  cost_q_r;
  logic [NW-1:0]      par_q_r;
  logic               out_valid_r;

  // Capacity clamp for loads.
  logic [FW-1:0] cap_clamp;
  always_comb begin
    if (in_capacity == '0)                         cap_clamp = FW'(1);
    else if ({28'd0, in_capacity} > 32'(WAYS))     cap_clamp = FW'(WAYS);
    else                                           cap_clamp = FW'(in_capacity);
  end

  // Lookup on the registered row: find hit, pick victim, build new row.
  logic                    hit;
  logic [WW-1:0]           hit_way, lru_way, way_sel;
  logic [WW-1:0]           old_rank;
  logic [FW-1:0]           fill_new;
  logic [WAYS-1:0][KW-1:0] tags_new;
  logic [WAYS-1:0][WW-1:0] ranks_new;
  logic [QCOST_W:0]        qsum;
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    lru_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (FW'(i) < fill_q_r && tags_r[i] == key_r && !hit) begin
        hit     = 1'b1;
        hit_way = WW'(i);
      end
      if (FW'(i) < fill_q_r && {1'b0, ranks_r[i]} == FW'(fill_q_r - FW'(1)))
        lru_way = WW'(i);
    end
    fill_new = fill_q_r;
    tags_new = tags_r;
    if (hit) begin
      way_sel  = hit_way;
      old_rank = ranks_r[hit_way];
    end else if (fill_q_r < cap_q_r) begin
      way_sel  = WW'(fill_q_r);
      old_rank = WW'(fill_q_r);
      fill_new = fill_q_r + FW'(1);
    end else begin
      way_sel  = lru_way;
      old_rank = ranks_r[lru_way];
    end
    if (!hit) tags_new[way_sel] = key_r;
    // Age entries more recent than the touched way; touched way becomes rank 0.
    ranks_new = ranks_r;
    for (int i = 0; i < WAYS; i++) begin
      if (FW'(i) < fill_new && ranks_r[i] < old_rank && WW'(i) != way_sel)
        ranks_new[i] = ranks_r[i] + WW'(1);
    end
    ranks_new[way_sel] = '0;
    qsum = qcost_r + (QCOST_W+1)'(cost_q_r);
    if (qsum > (QCOST_W+1)'(255)) qsum = (QCOST_W+1)'(255);
  end

  // Walk ends at root or at the level cap (read) or on hit (look).
  always_comb begin
    sts.is_load  = (op_r == OP_LOAD);
    sts.walk_end = cmd.do_read ? (cur_r == '0 || level_r == LW'(NODES)) : hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NODES; n++) begin
        parent_r[n] <= '0;
        cap_r[n]    <= FW'(1);
        cost_r[n]   <= COST_W'(1);
        fill_r[n]   <= '0;
      end
      root_cost_r <= RCOST_W'(1);
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.do_done;
      if (cfg_we) root_cost_r <= cfg_wdata;
      if (cmd.do_load) begin
        parent_r[node_r] <= par_r;
        cap_r[node_r]    <= cap_in_r;
        cost_r[node_r]   <= cost_of(CAP_W'(cap_in_r));
        fill_r[node_r]   <= '0;
      end
      if (cmd.do_look) fill_r[cur_r] <= fill_new;
      if (cmd.do_done && op_r == OP_QUERY) begin
        if (TOTAL_MAX - total_r < TOTAL_W'(qcost_r)) total_r <= TOTAL_MAX;
        else total_r <= total_r + TOTAL_W'(qcost_r);
      end
    end
  end

  // Payload registers and the row memory.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_op;
      node_r   <= NW'(in_node % NODES);
      key_r    <= KW'(in_key);
      par_r    <= NW'(in_parent_node % NODES);
      cap_in_r <= cap_clamp;
      cur_r    <= NW'(in_node % NODES);
      level_r  <= '0;
      qcost_r  <= '0;
    end
    if (cmd.do_read) begin
      tags_r   <= tag_mem[cur_r];
      ranks_r  <= rank_mem[cur_r];
      fill_q_r <= fill_r[cur_r];
      cap_q_r  <= cap_r[cur_r];
      cost_q_r <= cost_r[cur_r];
      par_q_r  <= parent_r[cur_r];
      if (cur_r == '0 && level_r != LW'(NODES)) begin
        qcost_r <= qcost_r + (QCOST_W+1)'(root_cost_r);
      end
    end
    if (cmd.do_look) begin
      tag_mem[cur_r]  <= tags_new;
      rank_mem[cur_r] <= ranks_new;
      qcost_r         <= qsum;
      cur_r           <= par_q_r;
      level_r         <= level_r + LW'(1);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_query_cost = (qcost_r > (QCOST_W+1)'(255)) ? 8'hFF : qcost_r[QCOST_W-1:0];
  assign out_total_cost = total_r;

endmodule

@@ rtl/lru_cache_tree_cost_model_unit.sv @@
// Top level of the LRU cache tree cost unit.
// A load captures the request, writes the node's entry, then strobes out_valid; a query
// walks from the node toward the root and stops on a hit, after reading the root or at
// the level cap; each level reads the row, then updates it.
// busy drops in the out_valid cycle, so the next start is taken at the edge ending the
// strobe; the receiver cannot stall. Sync reset empties node tables, clears total; root_cost to 1.
module lru_cache_tree_cost_model_unit import lctcm_pkg::*; #(
  parameter int NODES    = NODES_DEF,
  parameter int WAYS     = WAYS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_op,
  input  logic [NODE_W-1:0]   in_node,
  input  logic [IN_KEY_W-1:0] in_key,
  input  logic [NODE_W-1:0]   in_parent_node,
  input  logic [CAP_W-1:0]    in_capacity,
  input  logic                cfg_we,
  input  logic [RCOST_W-1:0]  cfg_wdata,
  output logic                out_valid,
  output logic [QCOST_W-1:0]  out_query_cost,
  output logic [TOTAL_W-1:0]  out_total_cost
);

  lctcm_cmd_t cmd;
  lctcm_sts_t sts;
  logic       busy_c;

  // Sequence each transfer: capture, then load or walk, then strobe.
  lctcm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy_c)
  );

  // Hold node tables, tag rows and running sums.
  lctcm_dp #(
    .NODES    (NODES),
    .WAYS     (WAYS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_node        (in_node),
    .in_key         (in_key),
    .in_parent_node (in_parent_node),
    .in_capacity    (in_capacity),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_query_cost (out_query_cost),
    .out_total_cost (out_total_cost)
  );

  assign busy = busy_c;

endmodule
